>>> sv/aipw_pkg.sv
// ============================================================================
// aipw_pkg
// Shared types and fixed constants for the affine inverse pixel warp.
// ============================================================================
package aipw_pkg;

  // Fixed field widths of the register interface
  localparam int COEF_W    = 32;  // signed fixed-point matrix terms
  localparam int CFG_DIM_W = 10;  // image width / height register
  localparam int CFG_IDX_W = 3;   // register index

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A       = 3'd0,
    REG_COEF_B       = 3'd1,
    REG_COEF_C       = 3'd2,
    REG_COEF_D       = 3'd3,
    REG_COEF_E       = 3'd4,
    REG_COEF_F       = 3'd5,
    REG_IMAGE_WIDTH  = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } cfg_reg_t;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Control that travels with each pipeline stage
  typedef struct packed {
    logic vld;   // stage holds a transaction
    logic load;  // transaction is a load (no result)
  } stg_t;

endpackage

>>> sv/affine_inverse_pixel_warp.sv
// ============================================================================
// affine_inverse_pixel_warp
// Inverse affine mapping with nearest-neighbor sampling. Loads fill the
// frame store; fetches map an output pixel to its source and read it.
//
//   channel | direction | signals
//   --------+-----------+------------------------------------------------
//   in      | sink      | in_valid, in_ready, req_type, pix_x, pix_y,
//           |           | pix_value
//   out     | source    | out_valid, out_ready, out_value, inside_res
//   cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One transaction per cycle unless out stalls. A fetch result passes through
// four register stages, the first loaded at the edge that accepts it:
// multiply, sum, round/range check, then the frame store read port.
// Loads write the store in the same slot a fetch reads it, so order holds.
// Reset clears the pipeline valids and loads the default matrix and size;
// the frame store is not cleared. A stall on out freezes every stage.
// ============================================================================
module affine_inverse_pixel_warp
  import aipw_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // config
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_data,
  // input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [$clog2(MAX_WIDTH)-1:0]  pix_x,
  input  logic [$clog2(MAX_HEIGHT)-1:0] pix_y,
  input  logic [PIXEL_BITS-1:0]         pix_value,
  // output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [PIXEL_BITS-1:0]         out_value,
  output logic                          inside_res
);

  localparam int X_BITS  = $clog2(MAX_WIDTH);
  localparam int Y_BITS  = $clog2(MAX_HEIGHT);
  localparam int C_W     = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int PROD_W  = COEF_W + C_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int WD_W    = $clog2(MAX_WIDTH + 1);
  localparam int HD_W    = $clog2(MAX_HEIGHT + 1);
  localparam int DIM_W0  = (WD_W > HD_W) ? WD_W : HD_W;
  localparam int DIM_W   = (DIM_W0 > CFG_DIM_W) ? DIM_W0 : CFG_DIM_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(65536);
  localparam logic [DIM_W-1:0] RST_W_LIM = DIM_W'((MAX_WIDTH < 512) ? MAX_WIDTH : 512);
  localparam logic [DIM_W-1:0] RST_H_LIM = DIM_W'((MAX_HEIGHT < 512) ? MAX_HEIGHT : 512);

  // Configuration registers
  logic signed [COEF_W-1:0] coef_a, coef_b, coef_d, coef_e;
  logic signed [SUM_W-1:0]  c_bias, f_bias;
  logic        [DIM_W-1:0]  w_lim, h_lim;
  logic        [DIM_W-1:0]  cfg_dim;

  // Pipeline
  logic                    adv;
  stg_t                    s1, s2, s3;
  logic [X_BITS-1:0]       x1, x2, x3;
  logic [Y_BITS-1:0]       y1, y2, y3;
  logic [PIXEL_BITS-1:0]   val1, val2, val3;
  logic                    hit_u, hit_v;
  logic [X_BITS-1:0]       u3;
  logic [Y_BITS-1:0]       v3;
  logic [X_BITS-1:0]       sel_x;
  logic [Y_BITS-1:0]       sel_y;
  logic [ADDR_W-1:0]       addr;
  logic                    ld_ok;
  logic                    store_we;
  logic                    o_vld;
  logic                    o_inside;
  logic [PIXEL_BITS-1:0]   rd_data;

  // --------------------------------------------------------------------------
  // Configuration: width/height saturated and constant terms pre-biased
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_dim   = DIM_W'(cfg_data[CFG_DIM_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= COEF_ONE;
      coef_b <= '0;
      c_bias <= HALF;
      coef_d <= '0;
      coef_e <= COEF_ONE;
      f_bias <= HALF;
      w_lim  <= RST_W_LIM;
      h_lim  <= RST_H_LIM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_A:       coef_a <= $signed(cfg_data);
        REG_COEF_B:       coef_b <= $signed(cfg_data);
        REG_COEF_C:       c_bias <= SUM_W'($signed(cfg_data)) + HALF;
        REG_COEF_D:       coef_d <= $signed(cfg_data);
        REG_COEF_E:       coef_e <= $signed(cfg_data);
        REG_COEF_F:       f_bias <= SUM_W'($signed(cfg_data)) + HALF;
        REG_IMAGE_WIDTH:  w_lim  <= (cfg_dim > DIM_W'(MAX_WIDTH)) ?
                                    DIM_W'(MAX_WIDTH) : cfg_dim;
        REG_IMAGE_HEIGHT: h_lim  <= (cfg_dim > DIM_W'(MAX_HEIGHT)) ?
                                    DIM_W'(MAX_HEIGHT) : cfg_dim;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: everything moves unless a result sits untaken
  // --------------------------------------------------------------------------
  assign adv      = !o_vld || out_ready;
  assign in_ready = adv;

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1       <= '0;
      s2       <= '0;
      s3       <= '0;
      o_vld    <= 1'b0;
      o_inside <= 1'b0;
    end else if (adv) begin
      s1.vld   <= in_valid;
      s1.load  <= (req_type == REQ_LOAD);
      s2       <= s1;
      s3       <= s2;
      o_vld    <= s3.vld && !s3.load;
      o_inside <= hit_u && hit_v;
    end
  end

  // Load payload carried alongside the mapping
  always_ff @(posedge clk) begin
    if (adv) begin
      x1   <= pix_x;
      y1   <= pix_y;
      val1 <= pix_value;
      x2   <= x1;
      y2   <= y1;
      val2 <= val1;
      x3   <= x2;
      y3   <= y2;
      val3 <= val2;
    end
  end

  // --------------------------------------------------------------------------
  // Source coordinate units
  // --------------------------------------------------------------------------
  aipw_axis #(
    .X_BITS(X_BITS), .Y_BITS(Y_BITS), .FRAC_BITS(FRAC_BITS), .DIM_W(DIM_W),
    .OUT_BITS(X_BITS), .C_W(C_W), .PROD_W(PROD_W), .SUM_W(SUM_W)
  ) u_axis_u (
    .clk(clk), .adv(adv), .cx(coef_a), .cy(coef_b), .cb(c_bias),
    .x(pix_x), .y(pix_y), .lim(w_lim), .hit(hit_u), .coord(u3)
  );

  aipw_axis #(
    .X_BITS(X_BITS), .Y_BITS(Y_BITS), .FRAC_BITS(FRAC_BITS), .DIM_W(DIM_W),
    .OUT_BITS(Y_BITS), .C_W(C_W), .PROD_W(PROD_W), .SUM_W(SUM_W)
  ) u_axis_v (
    .clk(clk), .adv(adv), .cx(coef_d), .cy(coef_e), .cb(f_bias),
    .x(pix_x), .y(pix_y), .lim(h_lim), .hit(hit_v), .coord(v3)
  );

  // --------------------------------------------------------------------------
  // Stage 4: store address, load write, fetch read
  // --------------------------------------------------------------------------
  assign sel_x    = s3.load ? x3 : u3;
  assign sel_y    = s3.load ? y3 : v3;
  assign addr     = ADDR_W'(sel_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sel_x);
  assign ld_ok    = (int'(x3) < MAX_WIDTH) && (int'(y3) < MAX_HEIGHT);
  assign store_we = adv && s3.vld && s3.load && ld_ok;

  aipw_store #(
    .DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(PIXEL_BITS)
  ) u_store (
    .clk(clk), .re(adv), .we(store_we), .addr(addr), .wdata(val3),
    .rdata(rd_data)
  );

  // Result
  assign out_valid  = o_vld;
  assign inside_res = o_inside;
  assign out_value  = o_inside ? rd_data : '0;

`ifndef ASSERT_OFF
  // Store is written only by a valid load
  a_we_load: assert property (@(posedge clk) disable iff (rst)
    store_we |-> (s3.vld && s3.load))
    else $error("frame store written by a non-load");

  // An inside fetch always addresses a real store entry
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (s3.vld && !s3.load && hit_u && hit_v) |-> (int'(addr) < DEPTH))
    else $error("inside fetch address beyond store");

  // A stall only happens with a pending result, which then stays
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> (o_vld && $stable(o_inside)))
    else $error("pending result lost during stall");

  // Stalled stage 3 does not move
  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s3))
    else $error("stage 3 moved during stall");
`endif

endmodule

>>> sv/aipw_axis.sv
// ============================================================================
// aipw_axis
// One source coordinate: multiply, sum with rounding bias, round and range
// check. Three register stages, all advancing on adv.
// ============================================================================
module aipw_axis
  import aipw_pkg::*;
#(
  parameter int X_BITS    = 9,
  parameter int Y_BITS    = 9,
  parameter int FRAC_BITS = 16,
  parameter int DIM_W     = 10,
  parameter int OUT_BITS  = 9,
  parameter int C_W       = 9,
  parameter int PROD_W    = 42,
  parameter int SUM_W     = 44
) (
  input  logic                    clk,
  input  logic                    adv,
  input  logic signed [COEF_W-1:0] cx,     // term on x
  input  logic signed [COEF_W-1:0] cy,     // term on y
  input  logic signed [SUM_W-1:0]  cb,     // constant term plus half
  input  logic        [X_BITS-1:0] x,
  input  logic        [Y_BITS-1:0] y,
  input  logic        [DIM_W-1:0]  lim,    // saturated image extent
  output logic                    hit,
  output logic        [OUT_BITS-1:0] coord
);

  localparam int IDX_W = SUM_W - FRAC_BITS;

  logic signed [C_W:0]      xs;
  logic signed [C_W:0]      ys;
  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic signed [SUM_W-1:0]  t;
  logic        [IDX_W-1:0]  idx;
  logic                     pos;

  assign xs = $signed({1'b0, (C_W)'(x)});
  assign ys = $signed({1'b0, (C_W)'(y)});

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (adv) begin
      px <= PROD_W'(cx) * PROD_W'(xs);
      py <= PROD_W'(cy) * PROD_W'(ys);
    end
  end

  // Stage 2: biased sum, exact
  always_ff @(posedge clk) begin
    if (adv) begin
      t <= SUM_W'(px) + SUM_W'(py) + cb;
    end
  end

  // Stage 3: round half away from zero and range check.
  // With t = sum + half, the rounded value is nonnegative exactly when
  // t > 0, and is then t >> FRAC_BITS.
  assign idx = t[SUM_W-1:FRAC_BITS];
  assign pos = !t[SUM_W-1] && (t != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      hit   <= pos && (idx < IDX_W'(lim));
      coord <= idx[OUT_BITS-1:0];
    end
  end

endmodule

>>> sv/aipw_store.sv
// ============================================================================
// aipw_store
// Frame store: one write and one registered read per cycle, the read only while re is high.
// ============================================================================
module aipw_store #(
  parameter int DEPTH  = 262144,
  parameter int ADDR_W = 18,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              re,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read, held while stalled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
